>>> rtl/core/obd_pkg.sv
// Shared constants, types and character helpers for the PID response decoder.
// Used by obd_parse, obd_conv and the top level; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package obd_pkg;

	// Sizing of the response buffer and of the hex pair store.
	localparam int RESPONSE_LIMIT = 128;
	localparam int MAX_PAIRS      = 8;
	localparam int FILL_W         = $clog2(RESPONSE_LIMIT);
	localparam int PAIR_W         = $clog2(MAX_PAIRS + 1);

	// Character classes for the first character of a pair.
	localparam logic [4:0] CLS_OTHER = 5'd16;
	localparam logic [4:0] CLS_WS    = 5'd17;
	localparam logic [4:0] CLS_PLUS  = 5'd18;
	localparam logic [4:0] CLS_MINUS = 5'd19;

	// Characters of interest.
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_SP     = 8'h20;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_VT     = 8'h0B;
	localparam logic [7:0] CH_FF     = 8'h0C;
	localparam logic [7:0] CH_PLUS   = 8'h2B;
	localparam logic [7:0] CH_MINUS  = 8'h2D;
	localparam logic [7:0] CH_PROMPT = 8'h3E;

	// Lengths of the watched error texts.
	localparam logic [2:0] NODATA_LEN = 3'd7;
	localparam logic [2:0] ERROR_LEN  = 3'd5;
	localparam logic [2:0] UNABLE_LEN = 3'd6;

	// Parser state captured when a response ends.
	typedef struct packed {
		logic [2:0]        flags;
		logic [PAIR_W-1:0] pairs;
		logic [7:0]        first;
		logic [7:0]        second;
	} obd_snap_t;

	// One decoded result item.
	typedef struct packed {
		logic signed [24:0] value_milli;
		logic [7:0]         byte_b;
		logic [7:0]         byte_a;
		logic [2:0]         data_count;
		logic [2:0]         status;
	} obd_res_t;

	// Hex digit value, or CLS_OTHER for anything else.
	function automatic logic [4:0] hex_val(input logic [7:0] c);
		logic [7:0] d;
		d = 8'd0;
		if (c inside {[8'h30:8'h39]}) begin
			d = c - 8'h30;
		end else if (c inside {[8'h61:8'h66]}) begin
			d = c - 8'h57;
		end else if (c inside {[8'h41:8'h46]}) begin
			d = c - 8'h37;
		end else begin
			d = {3'd0, CLS_OTHER};
		end
		return d[4:0];
	endfunction

	// Class of the first character of a pair.
	function automatic logic [4:0] classify(input logic [7:0] c);
		logic [4:0] h;
		h = hex_val(c);
		if (h != CLS_OTHER) return h;
		if (c inside {CH_TAB, CH_VT, CH_FF}) return CLS_WS;
		if (c == CH_PLUS) return CLS_PLUS;
		if (c == CH_MINUS) return CLS_MINUS;
		return CLS_OTHER;
	endfunction

	// Byte value of a pair in base 16: two digits, one digit alone, or blank, + or - and a digit.
	function automatic logic [7:0] pair_value(input logic [4:0] first, input logic [7:0] c);
		logic [4:0] h;
		h = hex_val(c);
		if (!first[4]) begin
			return (h[4]) ? {4'd0, first[3:0]} : {first[3:0], h[3:0]};
		end
		if (h[4]) return 8'd0;
		if (first == CLS_WS || first == CLS_PLUS) return {4'd0, h[3:0]};
		if (first == CLS_MINUS) return 8'd0 - {4'd0, h[3:0]};
		return 8'd0;
	endfunction

	// Characters of the watched texts by position.
	function automatic logic [7:0] nodata_chr(input logic [2:0] m);
		case (m)
			3'd0: return "N";
			3'd1: return "O";
			3'd2: return " ";
			3'd3: return "D";
			3'd4: return "A";
			3'd5: return "T";
			3'd6: return "A";
			default: return 8'd0;
		endcase
	endfunction

	function automatic logic [7:0] error_chr(input logic [2:0] m);
		case (m)
			3'd0: return "E";
			3'd1: return "R";
			3'd2: return "R";
			3'd3: return "O";
			3'd4: return "R";
			default: return 8'd0;
		endcase
	endfunction

	function automatic logic [7:0] unable_chr(input logic [2:0] m);
		case (m)
			3'd0: return "U";
			3'd1: return "N";
			3'd2: return "A";
			3'd3: return "B";
			3'd4: return "L";
			3'd5: return "E";
			default: return 8'd0;
		endcase
	endfunction

	// One step of a text matcher: returns {hit, next position}.
	function automatic logic [3:0] track(input logic [2:0] m, input logic [7:0] c,
			input logic [7:0] pm, input logic [7:0] p0, input logic [2:0] len);
		logic [2:0] mn;
		logic       hit;
		hit = 1'b0;
		if (m < len && c == pm) begin
			mn = m + 3'd1;
		end else begin
			mn = (c == p0) ? 3'd1 : 3'd0;
		end
		if (mn >= len) begin
			hit = 1'b1;
			mn  = 3'd0;
		end
		return {hit, mn};
	endfunction

endpackage

`default_nettype wire

>>> rtl/core/obd_parse.sv
// Character parser: whitespace collapse, error text matching and hex pair capture.
// Depends on obd_pkg; produces one snapshot item per finished response.
`timescale 1ns / 1ps
`default_nettype none

module obd_parse import obd_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       adv,
	input  wire logic       in_vld,
	input  wire logic       in_cmd,
	input  wire logic [7:0] in_char,
	output logic            snap_vld_s2,
	output obd_snap_t       snap_s2
);

	logic [FILL_W-1:0] fill_count_q, n_fill;
	logic              last_was_space_q, n_lws;
	logic              pair_half_q, n_half;
	logic [4:0]        first_digit_q, n_first;
	logic [PAIR_W-1:0] pair_count_q, n_pair;
	logic [7:0]        data_first_q, n_df;
	logic [7:0]        data_second_q, n_ds;
	logic [2:0]        nodata_match_q, n_nm;
	logic [2:0]        error_match_q, n_em;
	logic [2:0]        unable_match_q, n_um;
	logic [2:0]        found_flags_q, n_flags;
	logic              discarding_q;

	logic       emit, clr, disc_set, feed;
	logic [7:0] mc;
	logic [3:0] nm_t, em_t, um_t;

	// Text matchers run on the collapsed character.
	assign nm_t = track(nodata_match_q, mc, nodata_chr(nodata_match_q), "N", NODATA_LEN);
	assign em_t = track(error_match_q, mc, error_chr(error_match_q), "E", ERROR_LEN);
	assign um_t = track(unable_match_q, mc, unable_chr(unable_match_q), "U", UNABLE_LEN);

	// Next state for one item.
	always_comb begin
		n_fill   = fill_count_q;
		n_lws    = last_was_space_q;
		n_half   = pair_half_q;
		n_first  = first_digit_q;
		n_pair   = pair_count_q;
		n_df     = data_first_q;
		n_ds     = data_second_q;
		emit     = 1'b0;
		clr      = 1'b0;
		disc_set = 1'b0;
		feed     = 1'b0;
		mc       = in_char;
		if (in_vld) begin
			if (in_cmd) begin
				emit = !discarding_q;
				clr  = 1'b1;
			end else if (discarding_q) begin
				clr = (in_char == CH_PROMPT);
			end else begin
				if (in_char inside {CH_CR, CH_LF, CH_SP}) begin
					if (fill_count_q != '0 && !last_was_space_q) begin
						n_fill = fill_count_q + 1'b1;
						n_lws  = 1'b1;
						mc     = CH_SP;
						feed   = 1'b1;
					end
				end else begin
					n_fill = fill_count_q + 1'b1;
					n_lws  = 1'b0;
					feed   = 1'b1;
					if (in_char == CH_PROMPT) begin
						emit = 1'b1;
						clr  = 1'b1;
					end else if (!pair_half_q) begin
						n_first = classify(in_char);
						n_half  = 1'b1;
					end else begin
						n_half = 1'b0;
						if (pair_count_q < PAIR_W'(MAX_PAIRS)) begin
							if (pair_count_q == PAIR_W'(2)) n_df = pair_value(first_digit_q, in_char);
							if (pair_count_q == PAIR_W'(3)) n_ds = pair_value(first_digit_q, in_char);
							n_pair = pair_count_q + 1'b1;
						end
					end
				end
				// A full buffer ends the response and drops the rest up to the prompt or a cmd item.
				if (!clr && n_fill >= FILL_W'(RESPONSE_LIMIT - 1)) begin
					emit     = 1'b1;
					clr      = 1'b1;
					disc_set = 1'b1;
				end
			end
		end
		n_nm    = feed ? nm_t[2:0] : nodata_match_q;
		n_em    = feed ? em_t[2:0] : error_match_q;
		n_um    = feed ? um_t[2:0] : unable_match_q;
		n_flags = found_flags_q | (feed ? {um_t[3], em_t[3], nm_t[3]} : 3'd0);
	end

	// Parser state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_count_q     <= '0;
			last_was_space_q <= 1'b0;
			pair_half_q      <= 1'b0;
			first_digit_q    <= '0;
			pair_count_q     <= '0;
			data_first_q     <= '0;
			data_second_q    <= '0;
			nodata_match_q   <= '0;
			error_match_q    <= '0;
			unable_match_q   <= '0;
			found_flags_q    <= '0;
			discarding_q     <= 1'b0;
			snap_vld_s2      <= 1'b0;
		end else if (adv) begin
			snap_vld_s2 <= emit;
			if (clr) begin
				fill_count_q     <= '0;
				last_was_space_q <= 1'b0;
				pair_half_q      <= 1'b0;
				first_digit_q    <= '0;
				pair_count_q     <= '0;
				data_first_q     <= '0;
				data_second_q    <= '0;
				nodata_match_q   <= '0;
				error_match_q    <= '0;
				unable_match_q   <= '0;
				found_flags_q    <= '0;
				discarding_q     <= disc_set;
			end else begin
				fill_count_q     <= n_fill;
				last_was_space_q <= n_lws;
				pair_half_q      <= n_half;
				first_digit_q    <= n_first;
				pair_count_q     <= n_pair;
				data_first_q     <= n_df;
				data_second_q    <= n_ds;
				nodata_match_q   <= n_nm;
				error_match_q    <= n_em;
				unable_match_q   <= n_um;
				found_flags_q    <= n_flags;
			end
		end
	end

	// Snapshot payload for the converter.
	always_ff @(posedge clk) begin
		if (adv) begin
			snap_s2.flags  <= n_flags;
			snap_s2.pairs  <= n_pair;
			snap_s2.first  <= n_df;
			snap_s2.second <= n_ds;
		end
	end

`ifndef NO_ASSERTIONS
	a_pairs_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		pair_count_q <= PAIR_W'(MAX_PAIRS))
		else $error("pair count beyond store size");

	a_discard_clean: assert property (@(posedge clk) disable iff (!arst_n)
		discarding_q |-> (fill_count_q == '0 && pair_count_q == '0 && found_flags_q == '0))
		else $error("state kept while discarding");

	a_timeout_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && in_vld && in_cmd) |=> (fill_count_q == '0 && !discarding_q))
		else $error("timeout did not clear the response");
`endif

endmodule

`default_nettype wire

>>> rtl/core/obd_conv.sv
// Result converter: status, byte selection and PID value in thousandths.
// Depends on obd_pkg; two stages of constant multiplies around one register.
`timescale 1ns / 1ps
`default_nettype none

module obd_conv import obd_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       adv,
	input  wire logic [3:0] pid_select,
	input  wire logic       snap_vld,
	input  wire obd_snap_t  snap,
	output logic            res_vld,
	output obd_res_t        res
);

	localparam logic [2:0] ST_OK     = 3'd0;
	localparam logic [2:0] ST_NODATA = 3'd1;
	localparam logic [2:0] ST_ERROR  = 3'd2;
	localparam logic [2:0] ST_UNABLE = 3'd3;
	localparam logic [2:0] ST_TOOFEW = 3'd4;

	localparam logic [3:0] PID_RPM      = 4'd0;
	localparam logic [3:0] PID_SPEED    = 4'd1;
	localparam logic [3:0] PID_COOLANT  = 4'd2;
	localparam logic [3:0] PID_INTAKE   = 4'd3;
	localparam logic [3:0] PID_THROTTLE = 4'd4;
	localparam logic [3:0] PID_FUEL     = 4'd5;
	localparam logic [3:0] PID_BATTERY  = 4'd6;
	localparam logic [3:0] PID_TIMING   = 4'd7;
	localparam logic [3:0] PID_LOAD     = 4'd8;

	localparam logic [1:0] KIND_DIRECT = 2'd0;
	localparam logic [1:0] KIND_SPEED  = 2'd1;
	localparam logic [1:0] KIND_PCT    = 2'd2;

	// Reciprocals: floor(x/1000) for every x = 371*a + 500 with a below 256,
	// floor(y/51) for y below 2^23.
	localparam logic [13:0] RECIP_1000 = 14'd8389;
	localparam logic [23:0] RECIP_51   = 24'd10526881;

	logic [PAIR_W-1:0]  cnt_raw;
	logic [2:0]         status, count;
	logic [7:0]         a, b;
	logic [1:0]         kind, need;
	logic signed [24:0] val;
	logic [17:0]        spd_base;
	logic [16:0]        spd_x;
	logic [22:0]        pct_y;
	logic [23:0]        pct_x;
	logic signed [9:0]  temp_a;

	logic [2:0]         status_s3, count_s3;
	logic [7:0]         a_s3, b_s3;
	logic [1:0]         kind_s3;
	logic signed [24:0] val_s3;
	logic [17:0]        spd_base_s3;
	logic [16:0]        spd_x_s3;
	logic [22:0]        pct_y_s3;
	logic               vld_s3;

	logic [30:0]        spd_prod;
	logic [46:0]        pct_prod;

	// First stage: status, data bytes and the single-multiply conversions.
	always_comb begin
		cnt_raw  = (snap.pairs < PAIR_W'(3)) ? '0 : snap.pairs - PAIR_W'(2);
		status   = ST_OK;
		count    = 3'd0;
		a        = 8'd0;
		b        = 8'd0;
		kind     = KIND_DIRECT;
		val      = '0;
		need     = 2'd1;
		spd_base = 18'(a) * 18'd621;
		spd_x    = 17'(a) * 17'd371 + 17'd500;
		pct_x    = 24'(a) * 24'd40000 + 24'd51;
		pct_y    = pct_x[23:1];
		temp_a   = $signed({2'b00, a}) - 10'sd40;
		if (snap.flags != 3'd0) begin
			status = snap.flags[0] ? ST_NODATA : (snap.flags[1] ? ST_ERROR : ST_UNABLE);
		end else begin
			if (cnt_raw >= PAIR_W'(1)) a = snap.first;
			if (cnt_raw >= PAIR_W'(2)) b = snap.second;
			count = (cnt_raw > PAIR_W'(7)) ? 3'd7 : cnt_raw[2:0];
			need  = (pid_select == PID_RPM || pid_select == PID_BATTERY) ? 2'd2 : 2'd1;
			spd_base = 18'(a) * 18'd621;
			spd_x    = 17'(a) * 17'd371 + 17'd500;
			pct_x    = 24'(a) * 24'd40000 + 24'd51;
			pct_y    = pct_x[23:1];
			temp_a   = $signed({2'b00, a}) - 10'sd40;
			if (cnt_raw < PAIR_W'(need)) begin
				status = ST_TOOFEW;
			end else begin
				case (pid_select)
					PID_RPM:     val = $signed(25'({a, b}) * 25'd250);
					PID_SPEED:   kind = KIND_SPEED;
					PID_COOLANT, PID_INTAKE:
						val = 25'(temp_a) * 25'sd1800 + 25'sd32000;
					PID_THROTTLE, PID_FUEL, PID_LOAD:
						kind = KIND_PCT;
					PID_BATTERY: val = $signed({9'd0, a, b});
					PID_TIMING:  val = $signed(25'(a) * 25'd500) - 25'sd64000;
					default:     val = '0;
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (adv) begin
			vld_s3 <= snap_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			status_s3   <= status;
			count_s3    <= count;
			a_s3        <= a;
			b_s3        <= b;
			kind_s3     <= kind;
			val_s3      <= val;
			spd_base_s3 <= spd_base;
			spd_x_s3    <= spd_x;
			pct_y_s3    <= pct_y;
		end
	end

	// Second stage: reciprocal multiplies finish speed and percent.
	assign spd_prod = spd_x_s3 * RECIP_1000;
	assign pct_prod = pct_y_s3 * RECIP_51;

	always_comb begin
		res_vld        = vld_s3;
		res.status     = status_s3;
		res.data_count = count_s3;
		res.byte_a     = a_s3;
		res.byte_b     = b_s3;
		case (kind_s3)
			KIND_SPEED: res.value_milli = $signed({7'd0, spd_base_s3} + {17'd0, spd_prod[30:23]});
			KIND_PCT:   res.value_milli = $signed({7'd0, pct_prod[46:29]});
			default:    res.value_milli = val_s3;
		endcase
	end

endmodule

`default_nettype wire

>>> rtl/core/obd_pid_response_decoder.sv
// Top level of the PID response decoder: input register, parser, converter,
// output register with skid stage. Depends on obd_pkg, obd_parse and obd_conv.
//
//  Channel  Direction  Signals                      Payload
//  s_*      in         s_tvalid s_tready            tdata: rx_char; tuser: cmd
//  m_*      out        m_tvalid m_tready            tdata: status .. value_milli
//  cfg_*    in         cfg_valid cfg_ready          cfg_data: pid_select
//
// One item is accepted per clock while s_tready is high; the item that ends the
// response passes the input, snapshot, converter and output registers to m_tvalid.
// Reset clears the parser, pid_select and all valid flags.
// When the output stalls, the skid stage takes one result and s_tready drops
// until the output register drains it. cfg_ready is always high.
`timescale 1ns / 1ps
`default_nettype none

module obd_pid_response_decoder import obd_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,   // [7:0] rx_char
	input  wire logic [0:0]  s_tuser,   // [0] cmd
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [47:0]      m_tdata,   // [2:0] status, [5:3] data_count,
	                                    // [13:6] byte_a, [21:14] byte_b,
	                                    // [46:22] value_milli, [47] zero
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [3:0]  cfg_data
);

	logic       adv;
	logic       vld_s1, cmd_s1;
	logic [7:0] char_s1;
	logic [3:0] pid_select_q;

	logic       snap_vld_s2;
	obd_snap_t  snap_s2;
	logic       res_vld;
	obd_res_t   res;

	logic       out_vld_q, skid_vld_q, pop;
	obd_res_t   out_q, skid_q;

	// The pipeline moves whenever the skid stage is free.
	assign adv      = !skid_vld_q;
	assign s_tready = adv;
	assign cfg_ready = 1'b1;

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pid_select_q <= 4'd0;
		end else if (cfg_valid) begin
			pid_select_q <= cfg_data;
		end
	end

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			cmd_s1  <= s_tuser[0];
			char_s1 <= s_tdata;
		end
	end

	obd_parse u_parse (
		.clk         (clk),
		.arst_n      (arst_n),
		.adv         (adv),
		.in_vld      (vld_s1),
		.in_cmd      (cmd_s1),
		.in_char     (char_s1),
		.snap_vld_s2 (snap_vld_s2),
		.snap_s2     (snap_s2)
	);

	obd_conv u_conv (
		.clk        (clk),
		.arst_n     (arst_n),
		.adv        (adv),
		.pid_select (pid_select_q),
		.snap_vld   (snap_vld_s2),
		.snap       (snap_s2),
		.res_vld    (res_vld),
		.res        (res)
	);

	// Output register and skid stage.
	assign pop = out_vld_q && m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q  <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (skid_vld_q) begin
			if (pop) skid_vld_q <= 1'b0;
		end else if (res_vld) begin
			if (out_vld_q && !m_tready) skid_vld_q <= 1'b1;
			else out_vld_q <= 1'b1;
		end else if (pop) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_vld_q) begin
			if (pop) out_q <= skid_q;
		end else if (res_vld) begin
			if (out_vld_q && !m_tready) skid_q <= res;
			else out_q <= res;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = {1'b0, out_q};

`ifndef NO_ASSERTIONS
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_vld_q |-> out_vld_q)
		else $error("skid stage holds an item while the output is empty");
`endif

endmodule

`default_nettype wire
